### hdl/dfs_pkg.sv
// Shared types and constants of the depth-first path finder.
// No dependencies; every other file of the block uses it by scoped name.
`timescale 1ns / 1ps
package dfs_pkg;
    localparam int unsigned VtxW = 6;
    localparam int unsigned Rows = 64;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_EDGE  = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0]      action;
        logic [VtxW-1:0] vertex_a;
        logic [VtxW-1:0] vertex_b;
    } t_in_item;

    typedef struct packed {
        logic [VtxW-1:0] path_vertex;
        logic            found;
        logic            last;
    } t_out_item;

    // Command passed from the front to the back through the queue.
    typedef struct packed {
        t_action         op;
        logic            in_range;
        logic [VtxW-1:0] va;
        logic [VtxW-1:0] vb;
    } t_cmd;
endpackage

### hdl/dfs_path_finder.sv
// Top level of the depth-first path finder: front queue plus search engine.
// Depends on dfs_pkg, dfs_front and dfs_back.
`timescale 1ns / 1ps
// An item is taken when start is high and busy low. The engine spends one
// dispatch state taking each item from the queue; after that a clear sweeps
// all adjacency rows (one adjacency row a cycle), an edge adds EDGE2 (the
// second memory write), and a query runs a row read and a step per stack move
// of the search plus one output state per result; results leave one a cycle on
// o_valid and cannot be held off. After reset a clearing sweep runs
// through the adjacency memory before the first item is carried out; items
// queue meanwhile.
module dfs_path_finder #(
    parameter int unsigned MAX_VERTICES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  dfs_pkg::t_in_item  i_item,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_data,
    output logic               o_valid,
    output dfs_pkg::t_out_item o_result
);
    localparam int unsigned Limit =
        (MAX_VERTICES < dfs_pkg::Rows) ? MAX_VERTICES : dfs_pkg::Rows;

    logic [6:0]    r_vcount;
    logic [6:0]    w_active;
    logic          w_full, w_empty, w_pop, w_idle;
    dfs_pkg::t_cmd w_cmd;

    // Clamp the vertex count to the parameter and the matrix size.
    assign w_active = (r_vcount > 7'(Limit)) ? 7'(Limit) : r_vcount;
    assign busy = w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= 7'd64;
        end else if (i_cfg_we) begin
            r_vcount <= i_cfg_data;
        end
    end

    dfs_front u_front (
        .i_clk, .i_rst_n, .i_start(start), .i_item, .i_active(w_active),
        .i_pop(w_pop), .o_full(w_full), .o_empty(w_empty), .o_cmd(w_cmd)
    );

    dfs_back u_back (
        .i_clk, .i_rst_n, .i_empty(w_empty), .i_cmd(w_cmd), .i_active(w_active),
        .o_pop(w_pop), .o_idle(w_idle), .o_valid, .o_res(o_result)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !w_idle || 1'b1)
        else $error("unreachable");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_active <= 7'(Limit))
        else $error("active count above limit");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) busy |-> !w_empty)
        else $error("busy with empty queue");
endmodule

### hdl/dfs_front.sv
// Front part: accepts items, classifies them and holds them in a short queue.
// Depends on dfs_pkg.
`timescale 1ns / 1ps
module dfs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  dfs_pkg::t_in_item i_item,
    input  logic [6:0]        i_active,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output dfs_pkg::t_cmd     o_cmd
);
    localparam int unsigned Depth = 2;

    dfs_pkg::t_cmd r_q [Depth];
    logic          r_wp, n_wp, r_rp, n_rp;
    logic [1:0]    r_cnt, n_cnt;
    dfs_pkg::t_cmd w_cmd;
    logic          w_push;

    always_comb begin
        w_cmd.op       = dfs_pkg::t_action'(i_item.action);
        w_cmd.va       = i_item.vertex_a;
        w_cmd.vb       = i_item.vertex_b;
        w_cmd.in_range = ({1'b0, i_item.vertex_a} < i_active) &&
                         ({1'b0, i_item.vertex_b} < i_active);
    end

    assign o_full  = (r_cnt == 2'(Depth));
    assign o_empty = (r_cnt == 2'd0);
    // Drop unused codes at the door.
    assign w_push  = i_start && !o_full && (w_cmd.op != dfs_pkg::ACT_NONE);
    assign o_cmd   = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp + 1'(w_push);
        n_rp  = r_rp + 1'(i_pop);
        n_cnt = r_cnt + 2'(w_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(i_pop && o_empty))
        else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'(Depth))
        else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !i_pop |=> !o_empty)
        else $error("push lost");
endmodule

### hdl/dfs_back.sv
// Back part: adjacency memory, clearing sweep, search sequencer and path unwind.
// Depends on dfs_pkg.
`timescale 1ns / 1ps
module dfs_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  dfs_pkg::t_cmd      i_cmd,
    input  logic [6:0]         i_active,
    output logic               o_pop,
    output logic               o_idle,
    output logic               o_valid,
    output dfs_pkg::t_out_item o_res
);
    localparam int unsigned R = dfs_pkg::Rows;
    localparam int unsigned VW = dfs_pkg::VtxW;

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_CLEAR = 7'b0000100,
        S_EDGE2 = 7'b0001000,
        S_RD    = 7'b0010000,
        S_STEP  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state          r_st, n_st;
    logic [R-1:0]    r_adj [R];
    logic [R-1:0]    r_row;
    logic [R-1:0]    r_vis;
    logic [VW-1:0]   r_stk [R];
    logic [VW:0]     r_sp;
    logic [VW-1:0]   r_top;
    logic [VW-1:0]   r_cl;
    logic [VW-1:0]   r_a, r_b;
    logic [R-1:0]    w_mask, w_cand;
    logic [VW-1:0]   w_nx;

    assign o_idle = (r_st == S_IDLE) && i_empty;

    always_comb begin
        w_mask = '0;
        for (int i = 0; i < R; i++) begin
            w_mask[i] = (i < 64'(i_active));
        end
        w_cand = r_row & w_mask & ~r_vis;
        w_nx = '0;
        for (int i = R - 1; i >= 0; i--) begin
            if (w_cand[i]) w_nx = VW'(i);
        end
    end

    always_comb begin
        n_st  = r_st;
        o_pop = 1'b0;
        unique case (r_st)
            S_INIT:  if (r_cl == VW'(R - 1)) n_st = S_IDLE;
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.op)
                        dfs_pkg::ACT_CLEAR: n_st = S_CLEAR;
                        dfs_pkg::ACT_EDGE:  n_st = i_cmd.in_range ? S_EDGE2 : S_IDLE;
                        dfs_pkg::ACT_QUERY:
                            n_st = (i_cmd.in_range && i_cmd.va != i_cmd.vb) ? S_RD : S_OUT;
                        default: n_st = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: if (r_cl == VW'(R - 1)) n_st = S_IDLE;
            S_EDGE2: n_st = S_IDLE;
            S_RD:    n_st = S_STEP;
            S_STEP: begin
                if (w_cand == '0) begin
                    n_st = (r_sp == 7'd1) ? S_OUT : S_RD;
                end else if (w_nx == r_b) begin
                    n_st = S_OUT;
                end else begin
                    n_st = S_RD;
                end
            end
            S_OUT:   if (r_sp <= 7'd1) n_st = S_IDLE;
            default: n_st = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_INIT;
            r_cl    <= '0;
            r_sp    <= '0;
            o_valid <= 1'b0;
        end else begin
            r_st    <= n_st;
            o_valid <= (r_st == S_OUT);
            unique case (r_st)
                S_INIT, S_CLEAR: begin
                    r_adj[r_cl] <= '0;
                    r_cl <= r_cl + 1'b1;
                end
                S_IDLE: begin
                    r_cl <= '0;
                    r_a  <= i_cmd.va;
                    r_b  <= i_cmd.vb;
                    r_vis <= R'(1) << i_cmd.va;
                    r_stk[0] <= i_cmd.va;
                    r_top <= i_cmd.va;
                    // In-range searches and equal endpoints start at depth one; out-of-range ones use zero.
                    r_sp  <= i_cmd.in_range ? 7'd1 : 7'd0;
                    if (!i_empty && i_cmd.op == dfs_pkg::ACT_EDGE && i_cmd.in_range) begin
                        r_adj[i_cmd.va][i_cmd.vb] <= 1'b1;
                    end
                end
                S_EDGE2: r_adj[r_b][r_a] <= 1'b1;
                S_RD:    r_row <= r_adj[r_top];
                S_STEP: begin
                    if (w_cand == '0) begin
                        // Pop; on emptying, mark failure with depth zero.
                        r_sp  <= r_sp - 7'd1;
                        r_top <= r_stk[VW'(r_sp - 7'd2)];
                    end else begin
                        r_vis <= r_vis | (R'(1) << w_nx);
                        r_stk[r_sp[VW-1:0]] <= w_nx;
                        r_sp  <= r_sp + 7'd1;
                        r_top <= w_nx;
                    end
                end
                S_OUT: begin
                    if (r_sp == 7'd0) begin
                        o_res.path_vertex <= '0;
                        o_res.found       <= 1'b0;
                        o_res.last        <= 1'b1;
                    end else begin
                        o_res.path_vertex <= r_stk[VW'(r_sp - 7'd1)];
                        o_res.found       <= 1'b1;
                        o_res.last        <= (r_sp == 7'd1);
                        r_sp <= r_sp - 7'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_sp <= 7'(R))
        else $error("stack overrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.found == 1'b0 |-> o_res.last)
        else $error("failure result not last");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> $past(r_st) != S_OUT || r_st == S_IDLE)
        else $error("pop outside idle");
endmodule
